// ----- rtl/integer_set_membership_table_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef INTEGER_SET_MEMBERSHIP_TABLE_TOP_ASSERT_SVH
`define INTEGER_SET_MEMBERSHIP_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISMT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ismt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISMT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ismt assertion failed");

`endif

// ----- rtl/ismt_pkg.sv -----
`timescale 1ns / 1ps
package ismt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int MCNT_W   = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Search word walking down the chain of cells.
  typedef struct packed {
    logic             active;
    op_e              op;
    logic [VAL_W-1:0] value;
    logic             hit;
    logic             claimed;
  } token_t;

  // Broadcast from the tail decision back to every cell.
  typedef struct packed {
    logic ins;
    logic del;
  } commit_t;

endpackage

// ----- rtl/integer_set_membership_table_top.sv -----
`timescale 1ns / 1ps
// The search word walks the chain one cell a cycle; the tail decision then loads the output register.
// A new word is taken once the previous decision has loaded the output register.
// A result waiting at the output stalls the decision, not the search.
// Reset (async, active low) empties the set and clears the count; no clearing pass.
module integer_set_membership_table_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  logic signed [31:0]    value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  was_present_o,
  output logic [4:0]            member_count_o,
  output logic                  dropped_full_o
);

  ismt_pkg::token_t  tok [ismt_pkg::CAPACITY+1];
  ismt_pkg::token_t  hold_q, proc_tok;
  ismt_pkg::commit_t commit;

  logic                       busy_q;
  logic                       in_acc, out_free, proc_go;
  logic                       do_ins, do_drop;
  logic [ismt_pkg::CNT_W-1:0] count_q, count_d;
  logic                       out_valid_q, was_present_q, dropped_q;
  logic [ismt_pkg::MCNT_W-1:0] mcount_q;

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    tok[0].active  = in_acc;
    tok[0].op      = ismt_pkg::op_e'(opcode_i);
    tok[0].value   = $unsigned(value_i);
    tok[0].hit     = 1'b0;
    tok[0].claimed = 1'b0;
  end

  for (genvar g = 0; g < ismt_pkg::CAPACITY; g++) begin : g_cell
    ismt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[g]),
      .commit_i (commit),
      .tok_o    (tok[g+1])
    );
  end

  // Take the word straight off the chain tail, or from the hold register.
  assign proc_tok = tok[ismt_pkg::CAPACITY].active ? tok[ismt_pkg::CAPACITY] : hold_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign proc_go  = proc_tok.active && out_free;

  assign do_ins  = (proc_tok.op == ismt_pkg::OP_INSERT) && !proc_tok.hit && proc_tok.claimed;
  assign do_drop = (proc_tok.op == ismt_pkg::OP_INSERT) && !proc_tok.hit && !proc_tok.claimed;

  assign commit.ins = proc_go && do_ins;
  assign commit.del = proc_go && (proc_tok.op == ismt_pkg::OP_DELETE) && proc_tok.hit;

  always_comb begin
    count_d = count_q;
    if (commit.ins) begin
      count_d = count_q + ismt_pkg::CNT_W'(1);
    end else if (commit.del) begin
      count_d = count_q - ismt_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      hold_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (proc_go) begin
        busy_q <= 1'b0;
      end
      if (proc_go) begin
        hold_q.active <= 1'b0;
      end else if (tok[ismt_pkg::CAPACITY].active) begin
        hold_q <= tok[ismt_pkg::CAPACITY];
      end
      if (proc_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go) begin
      was_present_q <= proc_tok.hit;
      dropped_q     <= do_drop;
      mcount_q      <= ismt_pkg::MCNT_W'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign was_present_o  = was_present_q;
  assign member_count_o = mcount_q;
  assign dropped_full_o = dropped_q;

endmodule

// ----- rtl/ismt_cell.sv -----
`timescale 1ns / 1ps
module ismt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ismt_pkg::token_t  tok_i,
  input  ismt_pkg::commit_t commit_i,
  output ismt_pkg::token_t  tok_o
);

  logic [ismt_pkg::VAL_W-1:0] val_q;
  logic                       vld_q, vld_d;
  logic                       mark_hit_q, mark_free_q;
  logic                       match, free_here;
  ismt_pkg::token_t           tok_d, tok_q;

  assign match     = tok_i.active && vld_q && (val_q == tok_i.value);
  assign free_here = tok_i.active && !vld_q && !tok_i.claimed;

  always_comb begin
    tok_d         = tok_i;
    tok_d.hit     = tok_i.hit | match;
    tok_d.claimed = tok_i.claimed | free_here;
  end

  // Apply the decision to the slot this cell marked during the search.
  always_comb begin
    vld_d = vld_q;
    if (commit_i.ins && mark_free_q) begin
      vld_d = 1'b1;
    end
    if (commit_i.del && mark_hit_q) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= '0;
      vld_q       <= 1'b0;
      mark_hit_q  <= 1'b0;
      mark_free_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      vld_q <= vld_d;
      if (tok_i.active) begin
        mark_hit_q  <= match;
        mark_free_q <= free_here;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // Park the value in a free slot; it only counts once the insert commits.
    if (free_here) begin
      val_q <= tok_i.value;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/ismt_checker.sv -----
`timescale 1ns / 1ps
`include "integer_set_membership_table_top_assert.svh"
module ismt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               was_present_o,
  input logic [4:0]         member_count_o,
  input logic               dropped_full_o
);

  // A stalled result holds its word.
  `ISMT_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable({was_present_o, member_count_o, dropped_full_o}))

  // One word in flight: no second accept right after the first.
  `ISMT_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)

  // A refused insert only happens on a full table.
  `ISMT_ASSERT_IMP(a_drop_full, out_valid_o && dropped_full_o, (member_count_o == 5'(ismt_pkg::CAPACITY)) && !was_present_o)

  // The count never passes capacity.
  `ISMT_ASSERT_IMP(a_count_cap, out_valid_o, {27'd0, member_count_o} <= 32'(ismt_pkg::CAPACITY))

endmodule

bind integer_set_membership_table_top ismt_checker u_ismt_checker (.*);
